// ----- sv/lsed_pkg.sv -----
package lsed_pkg;

	localparam int FRAC_BITS = 16;
	localparam int EXP_TABLE_DEPTH = 256;
	localparam int RA_W = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int MAG_W = 64 - FRAC_BITS;
	localparam int DEC_W = FRAC_BITS + 1;
	localparam int X_W = FRAC_BITS + 6;
	localparam int P_W = 2 * FRAC_BITS + 6;
	localparam int RATE_W = 31;
	localparam int CFG_DATA_W = 31;
	localparam int CFG_IDX_W = 3;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [63:0] LN2_Q32 = 64'd2977044472;
	localparam logic [65:0] HALF = 66'd1 << (FRAC_BITS - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DECAY_RATE,
		CFG_DECAY_RATE_NEG,
		CFG_NEG_RATE_EN,
		CFG_TARGET_SPEED,
		CFG_STOP_SPEED,
		CFG_CLAMP_EN,
		CFG_MONO_EN,
		CFG_EXPAND_EN
	} cfg_idx_t;

	typedef struct packed {
		logic [RATE_W-1:0] decay_rate;
		logic [RATE_W-1:0] decay_rate_negative;
		logic              negative_rate_enable;
		logic [RATE_W-1:0] target_speed;
		logic [RATE_W-1:0] stop_speed;
		logic              clamp_enable;
		logic              monotonic_enable;
		logic              expand_enable;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		decay_rate: RATE_W'(1 << FRAC_BITS),
		decay_rate_negative: '0,
		negative_rate_enable: 1'b0,
		target_speed: '0,
		stop_speed: '0,
		clamp_enable: 1'b0,
		monotonic_enable: 1'b0,
		expand_enable: 1'b1
	};

	typedef struct packed {
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic signed [31:0] curvature;
		logic signed [31:0] grad_x;
		logic signed [31:0] grad_y;
		logic signed [31:0] grad_z;
		logic               in_closed_border;
	} point_t;

	typedef struct packed {
		logic signed [31:0] const_speed;
		logic signed [31:0] curv_speed;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
	} speed_t;

	typedef struct packed {
		logic               border;
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [31:0] nz;
		logic signed [31:0] curv;
	} side_t;

	typedef struct packed {
		side_t             side;
		logic              dneg;
		logic [MAG_W-1:0]  mdot;
	} lane_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
		logic [63:0] rad;
	} sq_t;

	typedef logic [32:0] rom_t [EXP_TABLE_DEPTH+1];

	// Entry i holds 2^(-i/depth) in Q32, from a truncated series of exp(-t).
	function automatic rom_t build_rom();
		rom_t r;
		logic [63:0] t;
		logic [63:0] term;
		logic signed [63:0] acc;
		for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
			t = (LN2_Q32 * 64'(i)) / 64'(EXP_TABLE_DEPTH);
			term = 64'd1 << 32;
			acc = $signed(64'd1 << 32);
			for (int k = 1; k <= 24; k++) begin
				term = ((term * t) >> 32) / 64'(k);
				if ((k & 1) != 0) begin
					acc = acc - $signed(term);
				end else begin
					acc = acc + $signed(term);
				end
			end
			r[i] = acc[32:0];
		end
		return r;
	endfunction

	localparam rom_t EXP_ROM = build_rom();

	// One digit of the restoring square root.
	function automatic sq_t sq_step(input sq_t a);
		logic [35:0] r;
		logic [35:0] t;
		sq_t b;
		r = {a.rem, a.rad[63:62]};
		t = {2'b00, a.root, 2'b01};
		b.rad = {a.rad[61:0], 2'b00};
		if (r >= t) begin
			b.rem = 34'(r - t);
			b.root = {a.root[30:0], 1'b1};
		end else begin
			b.rem = r[33:0];
			b.root = {a.root[30:0], 1'b0};
		end
		return b;
	endfunction

	function automatic logic [65:0] rnd_shift(input logic [65:0] p);
		return (p + HALF) >> FRAC_BITS;
	endfunction

	// Sign and magnitude to a saturated 32-bit value.
	function automatic logic signed [31:0] sat_sm(input logic neg, input logic [65:0] mag);
		logic signed [31:0] r;
		if (neg) begin
			if (mag > 66'h0_8000_0000) begin
				r = 32'sh8000_0000;
			end else begin
				r = 32'(66'd0 - mag);
			end
		end else begin
			if (mag > 66'h0_7FFF_FFFF) begin
				r = 32'sh7FFF_FFFF;
			end else begin
				r = mag[31:0];
			end
		end
		return r;
	endfunction

endpackage

// ----- sv/lsed_mag.sv -----
module lsed_mag
	import lsed_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        neg_en,
	input  logic        point_valid,
	input  point_t      point,
	output logic        mag_valid,
	output logic [63:0] sq,
	output lane_t       lane
);

	logic signed [63:0] ax, ay, az, gx, gy, gz;
	logic signed [63:0] px_s1, py_s1, pz_s1;
	logic               valid_s1, valid_s2;
	side_t              side_s1;
	logic signed [63:0] dot;
	logic [63:0]        sum;
	logic [63:0]        sq_s2;
	lane_t              lane_s2;

	always_comb begin
		gx = {{32{point.grad_x[31]}}, point.grad_x};
		gy = {{32{point.grad_y[31]}}, point.grad_y};
		gz = {{32{point.grad_z[31]}}, point.grad_z};
		ax = neg_en ? {{32{point.normal_x[31]}}, point.normal_x} : gx;
		ay = neg_en ? {{32{point.normal_y[31]}}, point.normal_y} : gy;
		az = neg_en ? {{32{point.normal_z[31]}}, point.normal_z} : gz;
	end

	always_comb begin
		dot = (px_s1 >>> FRAC_BITS) + (py_s1 >>> FRAC_BITS) + (pz_s1 >>> FRAC_BITS);
		sum = px_s1 + py_s1 + pz_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= point_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= ax * gx;
			py_s1 <= ay * gy;
			pz_s1 <= az * gz;
			side_s1.border <= point.in_closed_border;
			side_s1.nx <= point.normal_x;
			side_s1.ny <= point.normal_y;
			side_s1.nz <= point.normal_z;
			side_s1.curv <= point.curvature;
			sq_s2 <= sum;
			lane_s2.side <= side_s1;
			lane_s2.dneg <= dot[63];
			lane_s2.mdot <= dot[63] ? MAG_W'(64'd0 - dot) : MAG_W'(dot);
		end
	end

	assign mag_valid = valid_s2;
	assign sq = sq_s2;
	assign lane = lane_s2;

endmodule

// ----- sv/lsed_isqrt.sv -----
module lsed_isqrt
	import lsed_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        rad_valid,
	input  logic [63:0] rad,
	input  lane_t       rad_lane,
	output logic        root_valid,
	output logic [31:0] root,
	output lane_t       lane
);

	localparam int ROOT_W = 32;
	localparam int STEPS = 2;
	localparam int STAGES = ROOT_W / STEPS;

	sq_t   st_s    [STAGES];
	logic  valid_s [STAGES];
	lane_t lane_s  [STAGES];

	genvar i;
	for (i = 0; i < STAGES; i++) begin : g_stage
		sq_t   src;
		sq_t   nxt;
		logic  src_valid;
		lane_t src_lane;

		if (i == 0) begin : g_first
			assign src = {34'd0, 32'd0, rad};
			assign src_valid = rad_valid;
			assign src_lane = rad_lane;
		end else begin : g_next
			assign src = st_s[i-1];
			assign src_valid = valid_s[i-1];
			assign src_lane = lane_s[i-1];
		end

		always_comb begin
			nxt = src;
			for (int j = 0; j < STEPS; j++) begin
				nxt = sq_step(nxt);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (adv) begin
				valid_s[i] <= src_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[i] <= nxt;
				lane_s[i] <= src_lane;
			end
		end
	end

	assign root_valid = valid_s[STAGES-1];
	assign root = st_s[STAGES-1].root;
	assign lane = lane_s[STAGES-1];

endmodule

// ----- sv/lsed_exp.sv -----
module lsed_exp
	import lsed_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  cfg_t             cfg,
	input  logic             mag_valid,
	input  logic [MAG_W-1:0] mag,
	input  logic             dneg,
	input  side_t            mag_side,
	output logic             exp_valid,
	output logic [DEC_W-1:0] decay,
	output side_t            exp_side
);

	localparam int HLO = MAG_W / 2;
	localparam int HHI = MAG_W - HLO;
	localparam int PROD_W = RATE_W + MAG_W;
	localparam int K_W = X_W + 1 - FRAC_BITS;
	localparam int POS_W = FRAC_BITS + RA_W;
	localparam int S_W = 8;

	logic [RATE_W-1:0]       rate;
	logic [RATE_W+HLO-1:0]   plo_s1;
	logic [RATE_W+HHI-1:0]   phi_s1;
	logic [PROD_W-1:0]       prod;
	logic [X_W-1:0]          x_s2;
	logic [X_W+30:0]         yp;
	logic [K_W-1:0]          k_s3, k_s4, k_s5;
	logic [FRAC_BITS-1:0]    frac_s3, w_s4;
	logic [POS_W-1:0]        pos;
	logic [RA_W-1:0]         idx;
	logic [32:0]             r0_s4, r1_s4, v_s5, dif;
	logic [32+FRAC_BITS:0]   dw;
	logic [S_W-1:0]          sft;
	logic [5:0]              sh;
	logic [63:0]             rnd;
	logic [DEC_W-1:0]        decay_s6;
	logic                    zero_s2, zero_s3, zero_s4, zero_s5;
	logic                    valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	side_t                   side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;

	always_comb begin
		rate = (cfg.negative_rate_enable && dneg) ? cfg.decay_rate_negative : cfg.decay_rate;
		prod = (PROD_W'(phi_s1) << HLO) + PROD_W'(plo_s1);
		yp = (X_W+31)'(x_s2) * (X_W+31)'(LOG2E_Q30);
		pos = POS_W'(frac_s3) * POS_W'(EXP_TABLE_DEPTH);
		idx = pos[POS_W-1:FRAC_BITS];
		dif = r0_s4 - r1_s4;
		dw = (33+FRAC_BITS)'(dif) * (33+FRAC_BITS)'(w_s4);
		sft = S_W'(32 - FRAC_BITS) + S_W'(k_s5);
		sh = sft[5:0];
		rnd = (64'(v_s5) + (64'd1 << (sh - 6'd1))) >> sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= mag_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			plo_s1 <= (RATE_W+HLO)'(rate) * (RATE_W+HLO)'(mag[HLO-1:0]);
			phi_s1 <= (RATE_W+HHI)'(rate) * (RATE_W+HHI)'(mag[MAG_W-1:HLO]);
			side_s1 <= mag_side;

			x_s2 <= prod[P_W-1:FRAC_BITS];
			zero_s2 <= |prod[PROD_W-1:P_W];
			side_s2 <= side_s1;

			k_s3 <= yp[X_W+30:30+FRAC_BITS];
			frac_s3 <= yp[30+FRAC_BITS-1:30];
			zero_s3 <= zero_s2;
			side_s3 <= side_s2;

			r0_s4 <= EXP_ROM[idx];
			r1_s4 <= EXP_ROM[idx + RA_W'(1)];
			w_s4 <= pos[FRAC_BITS-1:0];
			k_s4 <= k_s3;
			zero_s4 <= zero_s3;
			side_s4 <= side_s3;

			v_s5 <= r0_s4 - dw[32+FRAC_BITS:FRAC_BITS];
			k_s5 <= k_s4;
			zero_s5 <= zero_s4;
			side_s5 <= side_s4;

			decay_s6 <= (zero_s5 || sft >= S_W'(64)) ? '0 : rnd[DEC_W-1:0];
			side_s6 <= side_s5;
		end
	end

	assign exp_valid = valid_s6;
	assign decay = decay_s6;
	assign exp_side = side_s6;

endmodule

// ----- sv/lsed_speed.sv -----
module lsed_speed
	import lsed_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  cfg_t             cfg,
	input  logic             dec_valid,
	input  logic [DEC_W-1:0] decay,
	input  side_t            dec_side,
	output logic             speed_valid,
	output speed_t           speed
);

	logic [31:0]               cmag;
	logic [RATE_W+DEC_W-1:0]   pt_s1;
	logic [32+DEC_W-1:0]       pc_s1;
	logic                      cpos_s1;
	logic [DEC_W-1:0]          decay_s1;
	logic signed [31:0]        dec32, f0, f1;
	logic signed [31:0]        f0_s2, f1_s2, f0_s3, f1_s3, f0_s4, f1_s4;
	logic signed [32:0]        sum;
	logic [32:0]               smag, smag_s3;
	logic                      hold, sneg_s3;
	logic [31:0]               nmx, nmy, nmz;
	logic [64:0]               pvx_s4, pvy_s4, pvz_s4;
	logic                      vnx_s4, vny_s4, vnz_s4, border_s4;
	speed_t                    out_s5;
	logic                      valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	side_t                     side_s1, side_s2, side_s3;

	always_comb begin
		cmag = dec_side.curv[31] ? (32'd0 - dec_side.curv) : dec_side.curv;
		dec32 = 32'(decay_s1);
		if (cfg.monotonic_enable) begin
			f0 = cfg.expand_enable ? dec32 : -dec32;
			f1 = '0;
		end else begin
			f0 = sat_sm(!cfg.expand_enable, rnd_shift(66'(pt_s1)));
			f1 = sat_sm(cpos_s1, rnd_shift(66'(pc_s1)));
		end
		sum = {f0_s2[31], f0_s2} + {f1_s2[31], f1_s2};
		smag = sum[32] ? (33'd0 - sum) : sum;
		hold = cfg.clamp_enable && (smag < 33'(cfg.stop_speed));
		nmx = side_s3.nx[31] ? (32'd0 - side_s3.nx) : side_s3.nx;
		nmy = side_s3.ny[31] ? (32'd0 - side_s3.ny) : side_s3.ny;
		nmz = side_s3.nz[31] ? (32'd0 - side_s3.nz) : side_s3.nz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= dec_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s1 <= (RATE_W+DEC_W)'(cfg.target_speed) * (RATE_W+DEC_W)'(decay);
			pc_s1 <= (32+DEC_W)'(cmag) * (32+DEC_W)'(decay);
			cpos_s1 <= !dec_side.curv[31] && (dec_side.curv != 32'sd0);
			decay_s1 <= decay;
			side_s1 <= dec_side;

			f0_s2 <= f0;
			f1_s2 <= f1;
			side_s2 <= side_s1;

			f0_s3 <= hold ? 32'sd0 : f0_s2;
			f1_s3 <= hold ? 32'sd0 : f1_s2;
			smag_s3 <= hold ? 33'd0 : smag;
			sneg_s3 <= sum[32] && !hold;
			side_s3 <= side_s2;

			pvx_s4 <= 65'(nmx) * 65'(smag_s3);
			pvy_s4 <= 65'(nmy) * 65'(smag_s3);
			pvz_s4 <= 65'(nmz) * 65'(smag_s3);
			vnx_s4 <= sneg_s3 ^ side_s3.nx[31];
			vny_s4 <= sneg_s3 ^ side_s3.ny[31];
			vnz_s4 <= sneg_s3 ^ side_s3.nz[31];
			f0_s4 <= f0_s3;
			f1_s4 <= f1_s3;
			border_s4 <= side_s3.border;

			if (border_s4) begin
				out_s5 <= '0;
			end else begin
				out_s5.const_speed <= f0_s4;
				out_s5.curv_speed <= f1_s4;
				out_s5.vel_x <= sat_sm(vnx_s4, rnd_shift(66'(pvx_s4)));
				out_s5.vel_y <= sat_sm(vny_s4, rnd_shift(66'(pvy_s4)));
				out_s5.vel_z <= sat_sm(vnz_s4, rnd_shift(66'(pvz_s4)));
			end
		end
	end

	assign speed_valid = valid_s5;
	assign speed = out_s5;

endmodule

// ----- sv/level_set_exp_decay_speed.sv -----
// Channel   Handshake                  Payload
// point     point_valid / point_stall  point_t: normal, curvature, gradient, border flag
// speed     speed_valid / speed_stall  speed_t: const and curvature terms, velocity
// config    cfg_write                  cfg_index, cfg_data
//
// One point per cycle while no stalled result holds the pipeline.
// The depth is set by the 16-stage square root, two result bits per stage.
// Reset clears all valid bits and loads the register defaults.
// A stalled result holds the whole pipeline, so nothing is dropped or repeated.
module level_set_exp_decay_speed
	import lsed_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  point_valid,
	output logic                  point_stall,
	input  point_t                point,
	output logic                  speed_valid,
	input  logic                  speed_stall,
	output speed_t                speed
);

	cfg_t             cfg_q;
	logic             adv;
	logic             mag_valid;
	logic [63:0]      sq;
	lane_t            mag_lane;
	logic             root_valid;
	logic [31:0]      root;
	lane_t            root_lane;
	logic [MAG_W-1:0] m_sel;
	logic             exp_valid;
	logic [DEC_W-1:0] decay;
	side_t            exp_side;

	assign adv = !(speed_valid && speed_stall);
	assign point_stall = !adv;
	assign m_sel = cfg_q.negative_rate_enable ? root_lane.mdot : MAG_W'(root);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DECAY_RATE:     cfg_q.decay_rate <= cfg_data;
				CFG_DECAY_RATE_NEG: cfg_q.decay_rate_negative <= cfg_data;
				CFG_NEG_RATE_EN:    cfg_q.negative_rate_enable <= cfg_data[0];
				CFG_TARGET_SPEED:   cfg_q.target_speed <= cfg_data;
				CFG_STOP_SPEED:     cfg_q.stop_speed <= cfg_data;
				CFG_CLAMP_EN:       cfg_q.clamp_enable <= cfg_data[0];
				CFG_MONO_EN:        cfg_q.monotonic_enable <= cfg_data[0];
				CFG_EXPAND_EN:      cfg_q.expand_enable <= cfg_data[0];
			endcase
		end
	end

	lsed_mag u_mag (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.neg_en      (cfg_q.negative_rate_enable),
		.point_valid (point_valid),
		.point       (point),
		.mag_valid   (mag_valid),
		.sq          (sq),
		.lane        (mag_lane)
	);

	lsed_isqrt u_isqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.rad_valid  (mag_valid),
		.rad        (sq),
		.rad_lane   (mag_lane),
		.root_valid (root_valid),
		.root       (root),
		.lane       (root_lane)
	);

	lsed_exp u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg_q),
		.mag_valid (root_valid),
		.mag       (m_sel),
		.dneg      (root_lane.dneg),
		.mag_side  (root_lane.side),
		.exp_valid (exp_valid),
		.decay     (decay),
		.exp_side  (exp_side)
	);

	lsed_speed u_speed (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.cfg         (cfg_q),
		.dec_valid   (exp_valid),
		.decay       (decay),
		.dec_side    (exp_side),
		.speed_valid (speed_valid),
		.speed       (speed)
	);

	a_decay_range: assert property (@(posedge clk) disable iff (!arst_n)
		exp_valid |-> (decay <= DEC_W'(1 << FRAC_BITS)))
		else $error("Decay exceeds one.");

	a_decay_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(decay))
		else $error("Decay changed while the pipeline was held.");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(speed_valid && speed_stall) |=> $stable(root_lane))
		else $error("Square root stage moved during a held result.");

endmodule
